[design/spms_pkg.sv]
// ----------------------------------------------------------------------------
// spms_pkg
// Shared codes for the shared-pool multi-stack unit: opcodes, result status
// codes and the configuration register map.
// ----------------------------------------------------------------------------
package spms_pkg;

   // request opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LIMIT    = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_BADIDX   = 3'd4;
   localparam logic [2:0] ST_HALTED   = 3'd5;

   // configuration register select (paddr bit 2)
   localparam logic REG_STACK_COUNT = 1'b0;
   localparam logic REG_TOTAL_LIMIT = 1'b1;

   localparam logic [6:0]  STACK_COUNT_RESET = 7'd64;
   localparam logic [10:0] TOTAL_LIMIT_RESET = 11'd1024;

endpackage

[design/shared_pool_multi_stack_unit.sv]
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_unit
// Several LIFO stacks kept as linked lists in one shared entry pool, with a
// free list, an occupancy limit, peak tracking and halt on first error.
// ----------------------------------------------------------------------------
// Sequence: a push or a request that ends on the head read (halted, bad index,
//   empty pop) gives its strobe from the head-read state; other pops first
//   read the top entry in the pop state. A new request is taken only when busy
//   is low; busy covers head read, entry read, write-back.
// Reset: synchronous; the stack head table is then cleared one entry a cycle,
//   all NUM_STACKS entries, with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_unit
   import spms_pkg::*;
#(
   parameter int NUM_STACKS = 64,
   parameter int POOL_DEPTH = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [5:0]  req_stack_index,
   input  logic [31:0] req_item_value,
   // result channel
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_popped_value,
   output logic [10:0] rsp_occupancy,
   output logic [10:0] rsp_peak_occupancy,
   output logic        rsp_balanced,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // pointer holds an entry number or the null mark (== POOL_DEPTH)
   localparam int ADDR_W = $clog2(POOL_DEPTH);
   localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
   localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [PTR_W-1:0]  NIL       = PTR_W'(POOL_DEPTH);
   localparam logic [SIDX_W-1:0] LAST_STACK = SIDX_W'(NUM_STACKS - 1);

   typedef enum logic [1:0] {
      S_CLEAR,  // head table clearing pass after reset
      S_IDLE,
      S_HEAD,   // head pointer and free-list link are valid
      S_POP     // top entry value and link are valid
   } state_type;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [6:0]  count_ff;
   logic [10:0] limit_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= STACK_COUNT_RESET;
         limit_ff <= TOTAL_LIMIT_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_STACK_COUNT: count_ff <= pwdata[6:0];
            REG_TOTAL_LIMIT: limit_ff <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_STACK_COUNT: prdata = 32'(count_ff);
         REG_TOTAL_LIMIT: prdata = 32'(limit_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // memories: stack heads, entry links, entry values
   // ---------------------------------------------------------------------
   logic [PTR_W-1:0]      heads_mem [NUM_STACKS];
   logic [PTR_W-1:0]      links_mem [POOL_DEPTH];
   logic [VALUE_BITS-1:0] values_mem [POOL_DEPTH];

   logic                  heads_we;
   logic [SIDX_W-1:0]     heads_wa;
   logic [PTR_W-1:0]      heads_wd;
   logic [SIDX_W-1:0]     heads_ra;
   logic [PTR_W-1:0]      head_rd_ff;

   logic                  links_we;
   logic [ADDR_W-1:0]     links_wa;
   logic [PTR_W-1:0]      links_wd;
   logic [ADDR_W-1:0]     links_ra;
   logic [PTR_W-1:0]      link_rd_ff;

   logic                  values_we;
   logic [ADDR_W-1:0]     values_wa;
   logic [VALUE_BITS-1:0] values_wd;
   logic [VALUE_BITS-1:0] value_rd_ff;

   always_ff @(posedge clock) begin
      if (heads_we) begin
         heads_mem[heads_wa] <= heads_wd;
      end
      head_rd_ff <= heads_mem[heads_ra];
   end

   always_ff @(posedge clock) begin
      if (links_we) begin
         links_mem[links_wa] <= links_wd;
      end
      link_rd_ff <= links_mem[links_ra];
   end

   always_ff @(posedge clock) begin
      if (values_we) begin
         values_mem[values_wa] <= values_wd;
      end
      value_rd_ff <= values_mem[head_rd_ff[ADDR_W-1:0]];
   end

   // ---------------------------------------------------------------------
   // control and bookkeeping
   // ---------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [SIDX_W-1:0]     clr_ff, clr_in;
   // free list: written entries come first; entries at or above the
   // watermark were never used and chain implicitly to the next one
   logic [PTR_W-1:0]      free_ff, free_in;
   logic [PTR_W-1:0]      wm_ff, wm_in;
   logic [PTR_W-1:0]      held_ff, held_in;
   logic [PTR_W-1:0]      peak_ff, peak_in;
   logic                  halted_ff, halted_in;
   // latched request
   logic                  op_ff, op_in;
   logic [5:0]            idx_ff, idx_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   // registered result
   logic                  strobe_ff, strobe_in;
   logic [2:0]            status_ff, status_in;
   logic [31:0]           popped_ff, popped_in;
   logic [10:0]           occ_ff, occ_in;
   logic [10:0]           pk_ff, pk_in;
   logic                  bal_ff, bal_in;

   logic [SIDX_W-1:0]     idx_addr;
   logic                  bad_index;
   logic                  over_limit;
   logic [PTR_W-1:0]      next_free;
   logic                  finish;
   logic [2:0]            fin_status;

   assign busy     = (state_ff != S_IDLE);
   assign idx_addr = SIDX_W'(16'(idx_ff));
   assign bad_index = (32'(idx_ff) >= 32'(count_ff)) || (32'(idx_ff) >= 32'(NUM_STACKS));
   assign over_limit = (32'(held_ff) + 32'd1 > 32'(limit_ff)) || (free_ff == NIL);
   assign next_free = (free_ff == wm_ff) ? wm_ff + PTR_W'(1) : link_rd_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      free_in   = free_ff;
      wm_in     = wm_ff;
      held_in   = held_ff;
      peak_in   = peak_ff;
      halted_in = halted_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      popped_in = popped_ff;
      occ_in    = occ_ff;
      pk_in     = pk_ff;
      bal_in    = bal_ff;

      heads_we  = 1'b0;
      heads_wa  = idx_addr;
      heads_wd  = NIL;
      // latched index keeps the head read stable while a request is in flight
      heads_ra  = idx_addr;
      links_we  = 1'b0;
      links_wa  = free_ff[ADDR_W-1:0];
      links_wd  = head_rd_ff;
      links_ra  = free_ff[ADDR_W-1:0];
      values_we = 1'b0;
      values_wa = free_ff[ADDR_W-1:0];
      values_wd = val_ff;

      finish     = 1'b0;
      fin_status = ST_OK;

      unique case (state_ff)
         S_CLEAR: begin
            heads_we = 1'b1;
            heads_wa = clr_ff;
            heads_wd = NIL;
            if (clr_ff == LAST_STACK) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + SIDX_W'(1);
            end
         end
         S_IDLE: begin
            // head read at req index, link read at free head on this edge
            heads_ra = SIDX_W'(16'(req_stack_index));
            if (start) begin
               op_in    = req_opcode;
               idx_in   = req_stack_index;
               val_in   = VALUE_BITS'(64'(req_item_value));
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            links_ra = head_rd_ff[ADDR_W-1:0];
            priority if (halted_ff) begin
               finish     = 1'b1;
               fin_status = ST_HALTED;
            end else if (bad_index) begin
               finish     = 1'b1;
               fin_status = ST_BADIDX;
            end else if (op_ff == OP_PUSH) begin
               finish = 1'b1;
               if (over_limit) begin
                  fin_status = ST_LIMIT;
               end else begin
                  values_we = 1'b1;
                  links_we  = 1'b1;
                  heads_we  = 1'b1;
                  heads_wd  = free_ff;
                  free_in   = next_free;
                  if (free_ff == wm_ff) begin
                     wm_in = wm_ff + PTR_W'(1);
                  end
                  held_in = held_ff + PTR_W'(1);
                  if (held_in > peak_ff) begin
                     peak_in = held_in;
                  end
               end
            end else if (head_rd_ff == NIL) begin
               finish     = 1'b1;
               fin_status = ST_EMPTY;
            end else begin
               // value and link of the top entry arrive next cycle
               state_in = S_POP;
            end
         end
         S_POP: begin
            links_ra = head_rd_ff[ADDR_W-1:0];
            finish   = 1'b1;
            if (value_rd_ff != val_ff) begin
               fin_status = ST_MISMATCH;
            end else begin
               heads_we  = 1'b1;
               heads_wd  = link_rd_ff;
               links_we  = 1'b1;
               links_wa  = head_rd_ff[ADDR_W-1:0];
               links_wd  = free_ff;
               free_in   = head_rd_ff;
               popped_in = 32'(64'(value_rd_ff));
               if (held_ff != '0) begin
                  held_in = held_ff - PTR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in  = S_IDLE;
         strobe_in = 1'b1;
         status_in = fin_status;
         if (fin_status != ST_OK) begin
            halted_in = 1'b1;
            popped_in = '0;
         end else if (op_ff == OP_PUSH) begin
            popped_in = '0;
         end
         occ_in = 11'(held_in);
         pk_in  = 11'(peak_in);
         bal_in = (held_in == '0) && !halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         free_ff   <= '0;
         wm_ff     <= '0;
         held_ff   <= '0;
         peak_ff   <= '0;
         halted_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         free_ff   <= free_in;
         wm_ff     <= wm_in;
         held_ff   <= held_in;
         peak_ff   <= peak_in;
         halted_ff <= halted_in;
         strobe_ff <= strobe_in;
      end
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      occ_ff    <= occ_in;
      pk_ff     <= pk_in;
      bal_ff    <= bal_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_popped_value   = popped_ff;
   assign rsp_occupancy      = occ_ff;
   assign rsp_peak_occupancy = pk_ff;
   assign rsp_balanced       = bal_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == S_HEAD || $past(state_ff) == S_POP))
      else $error("result strobe without a request in flight");

   a_held_wm: assert property (@(posedge clock) disable iff (reset)
      held_ff <= wm_ff)
      else $error("more entries held than ever allocated");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= held_ff)
      else $error("peak below current occupancy");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff != ST_OK) |-> halted_ff)
      else $error("error result without halt");

endmodule
